// File: rtl/core/asdt_pkg.sv
// shared constants, codes and request types for the single data transfer core
// no dependencies; used by asdt_rf, asdt_mem and arm_single_data_transfer_core

package asdt_pkg;

    // data memory geometry
    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int MEM_ROWS  = MEM_BYTES / 4;
    localparam int ROW_W     = MEM_AW - 2;
    localparam logic [31:0] MEM_LAST_WORD = 32'(MEM_BYTES - 4);

    // register file geometry
    localparam int RF_DEPTH = 16;
    localparam int RF_AW    = 4;

    // special addresses
    localparam logic [31:0] GPIO_SEL0 = 32'h2020_0000;
    localparam logic [31:0] GPIO_SEL1 = 32'h2020_0004;
    localparam logic [31:0] GPIO_SEL2 = 32'h2020_0008;
    localparam logic [31:0] GPIO_OFF  = 32'h2020_0028;
    localparam logic [31:0] GPIO_ON   = 32'h2020_001C;

    // shift kinds of a register offset
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_GPIO_SEL = 3'd1,
        ST_PIN_OFF  = 3'd2,
        ST_PIN_ON   = 3'd3,
        ST_OOB      = 3'd4,
        ST_SKIPPED  = 3'd5
    } status_t;

    // register file write
    typedef struct packed {
        logic             en;
        logic [RF_AW-1:0] addr;
        logic [31:0]      data;
    } rf_wr_t;

    // word access to the data memory (byte address, any alignment)
    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [MEM_AW-1:0] addr;
    } mem_req_t;

endpackage

// File: rtl/core/asdt_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies

module asdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/asdt_rf.sv
// 16 x 32 register file: two read ports, one write port, reads as zero until written
// depends on asdt_pkg and asdt_ram

module asdt_rf (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [asdt_pkg::RF_AW-1:0] raddr_a,
    input  logic [asdt_pkg::RF_AW-1:0] raddr_b,
    input  asdt_pkg::rf_wr_t        wr,
    output logic [31:0]             rdata_a,
    output logic [31:0]             rdata_b
);

    logic [asdt_pkg::RF_DEPTH-1:0] valid_reg;
    logic        vld_a_reg, vld_b_reg;
    logic        hit_a_reg, hit_b_reg;
    logic [31:0] byp_a_reg, byp_b_reg;
    logic [31:0] q_a, q_b;

    // one copy per read port, both written together
    asdt_ram #(.WIDTH(32), .DEPTH(asdt_pkg::RF_DEPTH)) u_bank_a (
        .aclk (aclk),
        .we   (wr.en),
        .waddr(wr.addr),
        .wdata(wr.data),
        .raddr(raddr_a),
        .rdata(q_a)
    );

    asdt_ram #(.WIDTH(32), .DEPTH(asdt_pkg::RF_DEPTH)) u_bank_b (
        .aclk (aclk),
        .we   (wr.en),
        .waddr(wr.addr),
        .wdata(wr.data),
        .raddr(raddr_b),
        .rdata(q_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            hit_a_reg <= wr.en && (wr.addr == raddr_a);
            hit_b_reg <= wr.en && (wr.addr == raddr_b);
            vld_a_reg <= valid_reg[raddr_a];
            vld_b_reg <= valid_reg[raddr_b];
        end
        byp_a_reg <= wr.data;
        byp_b_reg <= wr.data;
    end

    // same-cycle write wins over the stale array word
    assign rdata_a = hit_a_reg ? byp_a_reg : (vld_a_reg ? q_a : 32'd0);
    assign rdata_b = hit_b_reg ? byp_b_reg : (vld_b_reg ? q_b : 32'd0);

endmodule

// File: rtl/core/asdt_mem.sv
// byte-addressed little-endian data memory as four byte lanes, unaligned word access
// depends on asdt_pkg and asdt_ram; clears itself after reset

module asdt_mem (
    input  logic               aclk,
    input  logic               aresetn,
    input  asdt_pkg::mem_req_t req,
    input  logic [31:0]        wdata,
    output logic [31:0]        rdata,
    output logic               busy
);

    logic                       clr_busy_reg;
    logic [asdt_pkg::ROW_W-1:0] clr_row_reg;
    logic [1:0]                 lane_reg;
    logic [1:0]                 lane;
    logic [asdt_pkg::ROW_W-1:0] row;
    logic [7:0]                 q [4];

    assign lane = req.addr[1:0];
    assign row  = req.addr[asdt_pkg::MEM_AW-1:2];
    assign busy = clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_row_reg  <= '0;
        end else if (clr_busy_reg) begin
            if (clr_row_reg == asdt_pkg::ROW_W'(asdt_pkg::MEM_ROWS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
            clr_row_reg <= clr_row_reg + 1'b1;
        end
        lane_reg <= lane;
    end

    for (genvar k = 0; k < 4; k++) begin : g_lane
        logic [1:0]                 bidx;
        logic [asdt_pkg::ROW_W-1:0] brow;
        logic [7:0]                 bdata;
        logic                       bwe;
        logic [asdt_pkg::ROW_W-1:0] bwaddr;
        logic [7:0]                 bwdata;

        // lanes below the start lane hold bytes of the next row
        assign bidx   = 2'(k) - lane;
        assign brow   = row + asdt_pkg::ROW_W'(2'(k) < lane);
        assign bdata  = wdata[8*bidx +: 8];
        assign bwe    = clr_busy_reg || req.wr;
        assign bwaddr = clr_busy_reg ? clr_row_reg : brow;
        assign bwdata = clr_busy_reg ? 8'd0 : bdata;

        asdt_ram #(.WIDTH(8), .DEPTH(asdt_pkg::MEM_ROWS)) u_lane (
            .aclk (aclk),
            .we   (bwe),
            .waddr(bwaddr),
            .wdata(bwdata),
            .raddr(brow),
            .rdata(q[k])
        );
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            rdata[8*i +: 8] = q[2'(lane_reg + 2'(i))];
        end
    end

endmodule

// File: rtl/core/arm_single_data_transfer_core.sv
// word ldr/str execution: requests overlap in the pipe, but a new request is not accepted
// while the previous one is in stage b, since each register file port is read twice per request
// (rn/rm, then rs/rd), and the read-modify-write pipe runs through stages b, c, d and e around them
// reset: control clears at once; the data memory then runs a clearing pass over all
// MEM_BYTES/4 rows (16384) during which no request is accepted
// depends on asdt_pkg, asdt_rf, asdt_mem

module arm_single_data_transfer_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] instruction
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [2:0] status, [34:3] address, [66:35] load_value, rest 0
);

    typedef struct packed {
        logic [31:0]       value;
        logic [31:0]       addr;
        asdt_pkg::status_t status;
    } result_t;

    localparam int FIFO_DEPTH = 3;

    // instruction field helpers
    function automatic logic [3:0] f_rn(logic [31:0] ins);
        return ins[19:16];
    endfunction
    function automatic logic [3:0] f_rd(logic [31:0] ins);
        return ins[15:12];
    endfunction
    function automatic logic [3:0] f_rm(logic [31:0] ins);
        return ins[3:0];
    endfunction
    function automatic logic [3:0] f_rs(logic [31:0] ins);
        return ins[11:8];
    endfunction

    // register offset barrel shifter, amount zero passes the value through
    function automatic logic [31:0] shift_op(logic [31:0] v, logic [1:0] kind,
                                             logic [7:0] amt);
        logic [63:0] dbl;
        logic [31:0] res;
        logic        big;
        dbl = {v, v};
        big = |amt[7:5];
        case (kind)
            asdt_pkg::SH_LSL: res = big ? 32'd0 : (v << amt[4:0]);
            asdt_pkg::SH_LSR: res = big ? 32'd0 : (v >> amt[4:0]);
            asdt_pkg::SH_ASR: res = big ? {32{v[31]}} : 32'($signed(v) >>> amt[4:0]);
            asdt_pkg::SH_ROR: res = dbl[amt[4:0] +: 32];
            default:          res = v;
        endcase
        if (amt == 8'd0) begin
            res = v;
        end
        return res;
    endfunction

    // ---------------- shared state ----------------
    asdt_pkg::rf_wr_t   rf_wr;
    logic [3:0]         rf_raddr_a, rf_raddr_b;
    logic [31:0]        rf_q_a, rf_q_b;
    asdt_pkg::mem_req_t mem_req;
    logic [31:0]        mem_wdata, mem_rdata;
    logic               mem_busy;

    // ---------------- pipeline registers ----------------
    // b: rn/rm data returning, rs/rd being read
    logic        b_valid_reg;
    logic [31:0] b_ins_reg;
    // c: offset computed
    logic        c_valid_reg;
    logic [31:0] c_ins_reg;
    logic [31:0] c_rn_reg, c_rm_reg;
    // d: address, memory access, base writeback
    logic        d_valid_reg;
    logic [31:0] d_ins_reg;
    logic [31:0] d_base_reg, d_rd_reg, d_off_reg;
    logic        d_skip_reg;
    // e: load data returning, result pushed
    logic              e_valid_reg;
    asdt_pkg::status_t e_status_reg;
    logic [31:0]       e_addr_reg;
    logic [31:0]       e_imm_val_reg;
    logic              e_mem_load_reg;
    logic              e_rd_wr_reg;
    logic [3:0]        e_rd_reg;

    // ---------------- output queue and credits ----------------
    result_t    fifo_mem [FIFO_DEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [1:0] occ_reg;
    logic [1:0] credit_reg;     // requests in flight plus results queued

    logic s_acc, m_acc, push;

    // no request while the previous one is in stage b, never while the memory clears, never
    // more outstanding than the queue can take
    assign s_tready = !mem_busy && !b_valid_reg && (credit_reg < 2'(FIFO_DEPTH));
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = (occ_reg != 2'd0);
    assign m_acc    = m_tvalid && m_tready;
    assign m_tdata  = {5'd0, fifo_mem[rd_ptr_reg]};

    // a register value as seen now: a write this cycle by an older request wins
    function automatic logic [31:0] fwd(asdt_pkg::rf_wr_t w, logic [3:0] idx,
                                        logic [31:0] val);
        return (w.en && (w.addr == idx)) ? w.data : val;
    endfunction

    // ---------------- register file ----------------
    // port a: rn on accept, rs in stage b; port b: rm on accept, rd in stage b
    assign rf_raddr_a = b_valid_reg ? f_rs(b_ins_reg) : f_rn(s_tdata);
    assign rf_raddr_b = b_valid_reg ? f_rd(b_ins_reg) : f_rm(s_tdata);

    asdt_rf u_rf (
        .aclk   (aclk),
        .aresetn(aresetn),
        .raddr_a(rf_raddr_a),
        .raddr_b(rf_raddr_b),
        .wr     (rf_wr),
        .rdata_a(rf_q_a),
        .rdata_b(rf_q_b)
    );

    asdt_mem u_mem (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (mem_req),
        .wdata  (mem_wdata),
        .rdata  (mem_rdata),
        .busy   (mem_busy)
    );

    // ---------------- stage c: offset ----------------
    logic [31:0] c_rn_now, c_rm_now, c_rs_now, c_rd_now, c_off_next;
    logic [7:0]  c_amt;
    logic        c_skip_next;

    always_comb begin
        c_rn_now = fwd(rf_wr, f_rn(c_ins_reg), c_rn_reg);
        c_rm_now = fwd(rf_wr, f_rm(c_ins_reg), c_rm_reg);
        c_rs_now = fwd(rf_wr, f_rs(c_ins_reg), rf_q_a);
        c_rd_now = fwd(rf_wr, f_rd(c_ins_reg), rf_q_b);
        // amount from rs (low byte) or from the instruction
        c_amt    = c_ins_reg[4] ? c_rs_now[7:0] : {3'd0, c_ins_reg[11:7]};
        if (c_ins_reg[25]) begin
            c_off_next = shift_op(c_rm_now, c_ins_reg[6:5], c_amt);
        end else begin
            c_off_next = {20'd0, c_ins_reg[11:0]};
        end
        // post-indexed register offset with rm equal to rn does nothing
        c_skip_next = c_ins_reg[25] && !c_ins_reg[24] && (f_rm(c_ins_reg) == f_rn(c_ins_reg));
    end

    // ---------------- stage d: address and access ----------------
    logic [31:0]       d_sum, d_addr;
    logic              d_pre, d_load, d_in_mem, d_gpio_sel, d_post_wb;
    asdt_pkg::status_t d_status;
    asdt_pkg::rf_wr_t  d_wr, e_wr;

    always_comb begin
        d_pre      = d_ins_reg[24];
        d_load     = d_ins_reg[20];
        d_sum      = d_ins_reg[23] ? (d_base_reg + d_off_reg) : (d_base_reg - d_off_reg);
        d_addr     = (d_pre && !d_skip_reg) ? d_sum : d_base_reg;
        d_in_mem   = (d_addr <= asdt_pkg::MEM_LAST_WORD);
        d_gpio_sel = (d_addr == asdt_pkg::GPIO_SEL0) || (d_addr == asdt_pkg::GPIO_SEL1)
                  || (d_addr == asdt_pkg::GPIO_SEL2);
        if (d_skip_reg) begin
            d_status = asdt_pkg::ST_SKIPPED;
        end else if (d_in_mem) begin
            d_status = asdt_pkg::ST_DONE;
        end else if (d_gpio_sel) begin
            d_status = asdt_pkg::ST_GPIO_SEL;
        end else if (d_addr == asdt_pkg::GPIO_OFF) begin
            d_status = asdt_pkg::ST_PIN_OFF;
        end else if (d_addr == asdt_pkg::GPIO_ON) begin
            d_status = asdt_pkg::ST_PIN_ON;
        end else begin
            d_status = asdt_pkg::ST_OOB;
        end

        mem_req.rd   = d_valid_reg && (d_status == asdt_pkg::ST_DONE) && d_load;
        mem_req.wr   = d_valid_reg && (d_status == asdt_pkg::ST_DONE) && !d_load;
        mem_req.addr = d_addr[asdt_pkg::MEM_AW-1:0];
        mem_wdata    = d_rd_reg;

        // base writeback, or the address itself for a gpio select load
        d_post_wb = (d_status == asdt_pkg::ST_DONE) && !d_pre;
        d_wr.en   = d_valid_reg && (d_post_wb || ((d_status == asdt_pkg::ST_GPIO_SEL) && d_load));
        d_wr.addr = d_post_wb ? f_rn(d_ins_reg) : f_rd(d_ins_reg);
        d_wr.data = d_post_wb ? d_sum : d_addr;

        // a memory load lands in the cycle after its access, in stage e; stages d and e never write together
        e_wr.en   = e_valid_reg && e_rd_wr_reg;
        e_wr.addr = e_rd_reg;
        e_wr.data = mem_rdata;
        rf_wr     = e_wr.en ? e_wr : d_wr;
    end

    // ---------------- stage e: result ----------------
    result_t e_result;

    always_comb begin
        e_result.status = e_status_reg;
        e_result.addr   = e_addr_reg;
        e_result.value  = e_mem_load_reg ? mem_rdata : e_imm_val_reg;
    end

    assign push = e_valid_reg;

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            occ_reg     <= '0;
            credit_reg  <= '0;
        end else begin
            b_valid_reg <= s_acc;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == 2'(FIFO_DEPTH - 1)) ? 2'd0 : wr_ptr_reg + 2'd1;
            end
            if (m_acc) begin
                rd_ptr_reg <= (rd_ptr_reg == 2'(FIFO_DEPTH - 1)) ? 2'd0 : rd_ptr_reg + 2'd1;
            end
            occ_reg    <= occ_reg + 2'(push) - 2'(m_acc);
            credit_reg <= credit_reg + 2'(s_acc) - 2'(m_acc);
        end

        // payload
        b_ins_reg <= s_tdata;

        c_ins_reg <= b_ins_reg;
        c_rn_reg  <= fwd(rf_wr, f_rn(b_ins_reg), rf_q_a);
        c_rm_reg  <= fwd(rf_wr, f_rm(b_ins_reg), rf_q_b);

        d_ins_reg  <= c_ins_reg;
        d_base_reg <= c_rn_now;
        d_rd_reg   <= c_rd_now;
        d_off_reg  <= c_off_next;
        d_skip_reg <= c_skip_next;

        e_status_reg   <= d_status;
        e_addr_reg     <= d_addr;
        e_imm_val_reg  <= ((d_status == asdt_pkg::ST_GPIO_SEL) && d_load) ? d_addr : 32'd0;
        e_mem_load_reg <= (d_status == asdt_pkg::ST_DONE) && d_load;
        // post-indexed load into the base register keeps the written-back base
        e_rd_wr_reg    <= (d_status == asdt_pkg::ST_DONE) && d_load
                       && !(!d_pre && (f_rd(d_ins_reg) == f_rn(d_ins_reg)));
        e_rd_reg       <= f_rd(d_ins_reg);

        if (push) begin
            fifo_mem[wr_ptr_reg] <= e_result;
        end
    end

    // ---------------- checks ----------------
    ap_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_tready)
        else $error("request accepted in consecutive cycles");

    ap_one_rf_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(d_wr.en && e_wr.en))
        else $error("register file written by two stages at once");

    ap_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (occ_reg < 2'(FIFO_DEPTH)) || m_acc)
        else $error("result pushed into a full queue");

    ap_credit_covers: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= credit_reg)
        else $error("queued results exceed outstanding requests");

    ap_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_busy |-> !(mem_req.rd || mem_req.wr) && !d_valid_reg)
        else $error("memory access during clearing pass");

endmodule
